[hdl/qhd_pkg.sv]
// package: types, constants and helpers of the qam hard-decision demapper
package qhd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int MODE_W   = 4;
    localparam int BITS_W   = 8;
    localparam int BASE_W   = 16;
    localparam int FRAC_W   = SAMPLE_W - 4;
    localparam int PROD_W   = BASE_W + GAIN_W;
    localparam int GAIN_SH  = 16 + GAIN_W - 4;
    localparam int RND_SH   = GAIN_SH - FRAC_W;
    localparam int UNSC_SH  = 16;
    localparam int UNSC_W   = BASE_W + FRAC_W + 1;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int THR_W    = SAMPLE_W + 1;
    localparam int CMP_W    = SAMPLE_W + 5;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_QPSK   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_16QAM  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_64QAM  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_256QAM = 4'd8;
    localparam logic [MODE_W-1:0] MODE_RESET  = MODE_QPSK;

    localparam logic [BASE_W-1:0] BASE_16QAM  = 16'd41449;
    localparam logic [BASE_W-1:0] BASE_64QAM  = 16'd20225;
    localparam logic [BASE_W-1:0] BASE_256QAM = 16'd10053;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_phase;
        logic signed [SAMPLE_W-1:0] quadrature;
        logic        [GAIN_W-1:0]   channel_gain;
    } t_in_beat;

    typedef struct packed {
        logic [BITS_W-1:0] hard_bits;
        logic              unsupported_mode;
    } t_out_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic        [PROD_W-1:0]   prod;
        logic                       gain_zero;
        logic        [MODE_W-1:0]   mode;
    } t_mid_beat;

    typedef struct packed {
        logic [MAG_W-1:0]  xm;
        logic [MAG_W-1:0]  ym;
        logic              x_neg;
        logic              y_neg;
        logic              y_zero;
        logic [THR_W-1:0]  thr;
        logic [MODE_W-1:0] mode;
    } t_thr_beat;

    function automatic logic [BASE_W-1:0] base_for_mode(input logic [MODE_W-1:0] mode);
        logic [BASE_W-1:0] base;
        unique case (mode)
            MODE_16QAM:  base = BASE_16QAM;
            MODE_64QAM:  base = BASE_64QAM;
            MODE_256QAM: base = BASE_256QAM;
            default:     base = '0;
        endcase
        return base;
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [SAMPLE_W-1:0] v);
        logic signed [MAG_W-1:0] w;
        w = MAG_W'(v);
        return v[SAMPLE_W-1] ? MAG_W'(-w) : MAG_W'(w);
    endfunction

endpackage

[hdl/qhd_front.sv]
// front stage: takes input beats, tags the mode and forms base times gain
module qhd_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  qhd_pkg::t_in_beat          i_in_beat,
    input  logic [qhd_pkg::MODE_W-1:0] i_mode,
    output logic                       o_mid_valid,
    input  logic                       i_mid_ready,
    output qhd_pkg::t_mid_beat         o_mid_beat
);
    import qhd_pkg::*;

    logic              r_valid;
    logic              n_valid;
    t_mid_beat         r_beat;
    logic [BASE_W-1:0] base;
    logic              take;

    assign o_in_ready  = !r_valid || i_mid_ready;
    assign take        = i_in_valid && o_in_ready;
    assign base        = base_for_mode(i_mode);
    assign o_mid_valid = r_valid;
    assign o_mid_beat  = r_beat;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_mid_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_beat.x         <= i_in_beat.in_phase;
            r_beat.y         <= i_in_beat.quadrature;
            r_beat.prod      <= PROD_W'(base) * PROD_W'(i_in_beat.channel_gain);
            r_beat.gain_zero <= (i_in_beat.channel_gain == '0);
            r_beat.mode      <= i_mode;
        end
    end

endmodule

[hdl/qhd_queue.sv]
// short fifo between the front and back stages
module qhd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    output logic               o_push_ready,
    input  qhd_pkg::t_mid_beat i_push_beat,
    output logic               o_pop_valid,
    input  logic               i_pop_ready,
    output qhd_pkg::t_mid_beat o_pop_beat
);
    import qhd_pkg::*;

    t_mid_beat          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_beat   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_beat;
        end
    end

endmodule

[hdl/qhd_back.sv]
// back stages: threshold rounding, then gray decisions into the output register
module qhd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mid_valid,
    output logic               o_mid_ready,
    input  qhd_pkg::t_mid_beat i_mid_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output qhd_pkg::t_out_beat o_out_beat
);
    import qhd_pkg::*;

    logic               r_thr_valid;
    t_thr_beat          r_thr;
    logic               thr_ready;
    logic               thr_take;
    logic [PROD_W:0]    sum_gain;
    logic [UNSC_W-1:0]  sum_unsc;
    logic [THR_W-1:0]   thr_gain;
    logic [THR_W-1:0]   thr_unsc;

    logic               r_out_valid;
    t_out_beat          r_out;
    logic               out_take;
    t_out_beat          n_out;

    logic signed [CMP_W-1:0] a1;
    logic signed [CMP_W-1:0] a2;
    logic signed [CMP_W-1:0] a3;
    logic signed [CMP_W-1:0] a4;
    logic signed [CMP_W-1:0] xm;
    logic signed [CMP_W-1:0] ym;
    logic signed [CMP_W-1:0] dx;
    logic signed [CMP_W-1:0] dy;
    logic signed [CMP_W-1:0] dxa;
    logic signed [CMP_W-1:0] dya;
    logic signed [CMP_W-1:0] ex;
    logic signed [CMP_W-1:0] ey;
    logic signed [CMP_W-1:0] exa;
    logic signed [CMP_W-1:0] eya;

    // threshold stage
    assign thr_ready   = !r_thr_valid || out_take || !r_out_valid || i_out_ready;
    assign o_mid_ready = thr_ready;
    assign thr_take    = i_mid_valid && thr_ready;

    assign sum_gain = {1'b0, i_mid_beat.prod} + ((PROD_W + 1)'(1) << (RND_SH - 1));
    assign thr_gain = THR_W'(sum_gain >> RND_SH);
    assign sum_unsc = {1'b0, base_for_mode(i_mid_beat.mode), {FRAC_W{1'b0}}}
                    + (UNSC_W'(1) << (UNSC_SH - 1));
    assign thr_unsc = THR_W'(sum_unsc >> UNSC_SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_valid <= 1'b0;
        end else if (thr_ready) begin
            r_thr_valid <= i_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (thr_take) begin
            r_thr.xm     <= mag_of(i_mid_beat.x);
            r_thr.ym     <= mag_of(i_mid_beat.y);
            r_thr.x_neg  <= i_mid_beat.x[SAMPLE_W-1];
            r_thr.y_neg  <= i_mid_beat.y[SAMPLE_W-1];
            r_thr.y_zero <= (i_mid_beat.y == '0);
            r_thr.thr    <= i_mid_beat.gain_zero ? thr_unsc : thr_gain;
            r_thr.mode   <= i_mid_beat.mode;
        end
    end

    // decision stage
    assign out_take = r_thr_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        a1  = CMP_W'(r_thr.thr);
        a2  = a1 <<< 1;
        a3  = a1 + a2;
        a4  = a1 <<< 2;
        xm  = CMP_W'(r_thr.xm);
        ym  = CMP_W'(r_thr.ym);
        dx  = xm - a4;
        dy  = ym - a4;
        dxa = dx[CMP_W-1] ? -dx : dx;
        dya = dy[CMP_W-1] ? -dy : dy;
        ex  = dxa - a2;
        ey  = dya - a2;
        exa = ex[CMP_W-1] ? -ex : ex;
        eya = ey[CMP_W-1] ? -ey : ey;

        n_out = '0;
        unique case (r_thr.mode)
            MODE_QPSK: begin
                n_out.hard_bits[0] = r_thr.y_neg;
                n_out.hard_bits[1] = !r_thr.x_neg;
            end
            MODE_16QAM: begin
                n_out.hard_bits[0] = (ym <= a1);
                n_out.hard_bits[1] = r_thr.y_neg;
                n_out.hard_bits[2] = (xm <= a1);
                n_out.hard_bits[3] = !r_thr.x_neg;
            end
            MODE_64QAM: begin
                n_out.hard_bits[0] = (ym >= a1) && (ym <= a3);
                n_out.hard_bits[1] = (ym <= a2);
                n_out.hard_bits[2] = r_thr.y_neg || r_thr.y_zero;
                n_out.hard_bits[3] = (xm >= a1) && (xm <= a3);
                n_out.hard_bits[4] = (xm <= a2);
                n_out.hard_bits[5] = !r_thr.x_neg;
            end
            MODE_256QAM: begin
                n_out.hard_bits[0] = (eya <= a1);
                n_out.hard_bits[1] = (dya <= a2);
                n_out.hard_bits[2] = (ym <= a4);
                n_out.hard_bits[3] = r_thr.y_neg || r_thr.y_zero;
                n_out.hard_bits[4] = (exa <= a1);
                n_out.hard_bits[5] = (dxa <= a2);
                n_out.hard_bits[6] = (xm <= a4);
                n_out.hard_bits[7] = !r_thr.x_neg;
            end
            default: begin
                n_out.unsupported_mode = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

[hdl/qam_hard_decision_demapper_core.sv]
// top level of the qam hard-decision demapper
//
//  channel   direction  handshake                 beat
//  in        in         i_in_valid / o_in_ready   i_in_beat  (i, q, gain)
//  out       out        o_out_valid / i_out_ready o_out_beat (bits, flag)
//  cfg       in         i_cfg_we                  i_cfg_wdata (modulation order)
//
// one beat per clock sustained while the output is ready; each beat passes in order through
// the front multiply register, queue, threshold register and output register
// the single base-times-gain multiplier sets the stage split
// synchronous active-low reset empties all stages and sets order to qpsk
// a stalled output backs up through the two-entry queue to the input ready
module qam_hard_decision_demapper_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  qhd_pkg::t_in_beat          i_in_beat,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output qhd_pkg::t_out_beat         o_out_beat,
    input  logic                       i_cfg_we,
    input  logic [qhd_pkg::MODE_W-1:0] i_cfg_wdata
);
    import qhd_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic              front_valid;
    logic              front_ready;
    t_mid_beat         front_beat;
    logic              q_valid;
    logic              q_ready;
    t_mid_beat         q_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    qhd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .i_mode      (r_mode),
        .o_mid_valid (front_valid),
        .i_mid_ready (front_ready),
        .o_mid_beat  (front_beat)
    );

    qhd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_beat  (front_beat),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_beat   (q_beat)
    );

    qhd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (q_valid),
        .o_mid_ready (q_ready),
        .i_mid_beat  (q_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule
